// File: src/stepper_move_homing_sequencer_top_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef STEPPER_MOVE_HOMING_SEQUENCER_TOP_DEFINES_SVH
`define STEPPER_MOVE_HOMING_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SMHS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SMHS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/smhs_pkg.sv
`default_nettype none

package smhs_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_HOME  = 2'd1,
      OP_MOVE  = 2'd2,
      OP_SPEED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_HOME   = 3'd1,
      MODE_SETTLE = 3'd2,
      MODE_MOVE   = 3'd3,
      MODE_SPEED  = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_REVERSE   = 3'd0,
      CSR_SPEED_INT = 3'd1,
      CSR_ABSOLUTE  = 3'd2,
      CSR_UPPER     = 3'd3,
      CSR_SETTLE    = 3'd4
   } csr_index_type;

   localparam logic [16:0] STEPS_MAX         = 17'h1FFFF;
   localparam logic [7:0]  TICKS_SAT         = 8'hFF;
   localparam logic [15:0] SETTLE_SAT        = 16'hFFFF;
   localparam logic [3:0]  PHASE_FIRST_FWD   = 4'h1;
   localparam logic [3:0]  PHASE_FIRST_REV   = 4'h8;
   localparam logic [7:0]  RST_SPEED_INT     = 8'd1;
   localparam logic [15:0] RST_UPPER_LIMIT   = 16'd69;
   localparam logic [15:0] RST_SETTLE_TICKS  = 16'd1000;

   typedef struct packed {
      op_type             op;
      logic               home_switch;
      logic               hold;
      logic signed [16:0] target;
      logic               speed_direction;
   } item_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] position;
      logic [2:0]  mode;
      logic        homed;
      logic        encoder_clear;
      logic        stepped;
   } result_type;

   typedef struct packed {
      logic        reverse_direction;
      logic [7:0]  speed_interval;
      logic        absolute_moves;
      logic [15:0] upper_limit;
      logic [15:0] settle_ticks;
   } cfg_type;

   // One wave-drive step of the one-hot coil pattern.
   function automatic logic [3:0] phase_rotate(input logic [3:0] p, input logic fwd,
                                               input logic rev);
      logic [3:0] r;
      if (p == 4'h0) begin
         r = rev ? PHASE_FIRST_REV : PHASE_FIRST_FWD;
      end else if (fwd ^ rev) begin
         r = {p[2:0], p[3]};
      end else begin
         r = {p[0], p[3:1]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/smhs_if.sv
`default_nettype none

interface smhs_req_if import smhs_pkg::*; ();
   logic               valid;
   logic               ready;
   op_type             op;
   logic               home_switch;
   logic               hold;
   logic signed [16:0] target;
   logic               speed_direction;

   modport source (output valid, op, home_switch, hold, target, speed_direction,
                   input ready);
   modport sink   (input valid, op, home_switch, hold, target, speed_direction,
                   output ready);
endinterface

interface smhs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  phase;
   logic [15:0] position;
   logic [2:0]  mode;
   logic        homed;
   logic        encoder_clear;
   logic        stepped;

   modport source (output valid, phase, position, mode, homed, encoder_clear, stepped,
                   input ready);
   modport sink   (input valid, phase, position, mode, homed, encoder_clear, stepped,
                   output ready);
endinterface

interface smhs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/smhs_core.sv
`default_nettype none

module smhs_core import smhs_pkg::*; #(
   parameter int POSITION_WIDTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire item_type   item,
   input  wire cfg_type    cfg,
   output      result_type result
);

   localparam int PW = POSITION_WIDTH;
   localparam int DW = ((PW > 17) ? PW : 17) + 2;
   localparam int CW = ((PW > 16) ? PW : 16) + 1;

   mode_type          mode_ff, mode_in;
   logic [3:0]        phase_ff, phase_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [16:0]       steps_ff, steps_in;
   logic              move_fwd_ff, move_fwd_in;
   logic              run_fwd_ff, run_fwd_in;
   logic [7:0]        tss_ff, tss_in;
   logic [15:0]       settle_ff, settle_in;
   logic              homed_ff, homed_in;

   logic              stepped, clear;

   always_comb begin
      logic [7:0]            tss_inc;
      logic [15:0]           settle_inc;
      logic                  want_step;
      logic                  step_fwd;
      logic [7:0]            interval;
      logic signed [DW-1:0]  delta;
      logic signed [DW-1:0]  mag;
      logic                  at_upper;

      mode_in     = mode_ff;
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      steps_in    = steps_ff;
      move_fwd_in = move_fwd_ff;
      run_fwd_in  = run_fwd_ff;
      tss_in      = tss_ff;
      settle_in   = settle_ff;
      homed_in    = homed_ff;
      stepped     = 1'b0;
      clear       = 1'b0;

      tss_inc    = (tss_ff != TICKS_SAT) ? tss_ff + 8'd1 : tss_ff;
      settle_inc = (settle_ff != SETTLE_SAT) ? settle_ff + 16'd1 : settle_ff;
      at_upper   = CW'(pos_ff) >= CW'(cfg.upper_limit);
      want_step  = 1'b0;
      step_fwd   = 1'b0;
      interval   = 8'd1;

      delta = cfg.absolute_moves ? DW'(item.target) - $signed({{(DW-PW){1'b0}}, pos_ff})
                                 : DW'(item.target);
      mag   = (delta > 0) ? delta : -delta;

      case (item.op)
         OP_HOME: begin
            homed_in = 1'b0;
            mode_in  = MODE_HOME;
         end
         OP_MOVE: begin
            mode_in     = MODE_MOVE;
            move_fwd_in = delta > 0;
            steps_in    = ($unsigned(mag) > DW'(STEPS_MAX)) ? STEPS_MAX : mag[16:0];
         end
         OP_SPEED: begin
            mode_in    = MODE_SPEED;
            run_fwd_in = item.speed_direction;
         end
         default: begin
            tss_in = tss_inc;
            case (mode_ff)
               MODE_IDLE: ;
               MODE_HOME: begin
                  want_step = 1'b1;
               end
               MODE_SETTLE: begin
                  settle_in = settle_inc;
                  if (settle_inc >= cfg.settle_ticks) begin
                     clear   = 1'b1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_MOVE: begin
                  if (steps_ff != 17'd0) begin
                     want_step = 1'b1;
                     step_fwd  = move_fwd_ff;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_SPEED: begin
                  step_fwd = run_fwd_ff;
                  interval = cfg.speed_interval;
                  if (!item.hold && !(pos_ff == '0 && !run_fwd_ff)
                      && !(at_upper && run_fwd_ff)) begin
                     want_step = 1'b1;
                  end
               end
               default: mode_in = MODE_IDLE;
            endcase

            if (want_step && tss_inc >= interval) begin
               stepped  = 1'b1;
               tss_in   = 8'd0;
               phase_in = phase_rotate(phase_ff, step_fwd, cfg.reverse_direction);
               if (step_fwd) begin
                  pos_in = (pos_ff != '1) ? pos_ff + PW'(1) : pos_ff;
               end else begin
                  pos_in = (pos_ff != '0) ? pos_ff - PW'(1) : pos_ff;
               end
               if (mode_ff == MODE_MOVE) begin
                  steps_in = steps_ff - 17'd1;
               end
            end

            // switch is sampled after the backward step
            if (mode_ff == MODE_HOME && item.home_switch) begin
               mode_in   = MODE_SETTLE;
               settle_in = 16'd0;
               homed_in  = 1'b1;
               pos_in    = '0;
            end
         end
      endcase

      result.phase         = phase_in;
      result.position      = 16'(pos_in);
      result.mode          = mode_in;
      result.homed         = homed_in;
      result.encoder_clear = clear;
      result.stepped       = stepped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         phase_ff    <= 4'h0;
         pos_ff      <= '0;
         steps_ff    <= 17'd0;
         move_fwd_ff <= 1'b0;
         run_fwd_ff  <= 1'b0;
         tss_ff      <= TICKS_SAT;
         settle_ff   <= 16'd0;
         homed_ff    <= 1'b0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         steps_ff    <= steps_in;
         move_fwd_ff <= move_fwd_in;
         run_fwd_ff  <= run_fwd_in;
         tss_ff      <= tss_in;
         settle_ff   <= settle_in;
         homed_ff    <= homed_in;
      end
   end

endmodule

`default_nettype wire

// File: src/stepper_move_homing_sequencer_top.sv
// Path: an accepted item waits in the input stage; its result is then registered in the output stage for rsp_bus.
// Throughput: one item per cycle while rsp_bus takes results; smhs_core updates its state on each fire.
// A stalled result holds both stages; req ready drops only once both are full.
// Reset (synchronous, active high): idle, phase 0, position 0, step allowed,
// registers back to their defaults, both stages empty.
`default_nettype none
`include "stepper_move_homing_sequencer_top_defines.svh"

module stepper_move_homing_sequencer_top import smhs_pkg::*; #(
   parameter int POSITION_WIDTH = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   smhs_req_if.sink  req_bus,
   smhs_rsp_if.source rsp_bus,
   smhs_csr_if.sink  csr_bus
);

   logic       s1_valid_ff;
   item_type   s1_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type core_result;
   cfg_type    cfg_ff;
   logic       out_free;
   logic       fire;

   assign out_free    = !out_valid_ff || rsp_bus.ready;
   assign fire        = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || fire;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_item_ff.op              <= req_bus.op;
         s1_item_ff.home_switch     <= req_bus.home_switch;
         s1_item_ff.hold            <= req_bus.hold;
         s1_item_ff.target          <= req_bus.target;
         s1_item_ff.speed_direction <= req_bus.speed_direction;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reverse_direction <= 1'b0;
         cfg_ff.speed_interval    <= RST_SPEED_INT;
         cfg_ff.absolute_moves    <= 1'b0;
         cfg_ff.upper_limit       <= RST_UPPER_LIMIT;
         cfg_ff.settle_ticks      <= RST_SETTLE_TICKS;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_REVERSE:   cfg_ff.reverse_direction <= csr_bus.data[0];
            CSR_SPEED_INT: cfg_ff.speed_interval    <= csr_bus.data[7:0];
            CSR_ABSOLUTE:  cfg_ff.absolute_moves    <= csr_bus.data[0];
            CSR_UPPER:     cfg_ff.upper_limit       <= csr_bus.data;
            CSR_SETTLE:    cfg_ff.settle_ticks      <= csr_bus.data;
            default: ;
         endcase
      end
   end

   smhs_core #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= core_result;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.phase         = out_ff.phase;
   assign rsp_bus.position      = out_ff.position;
   assign rsp_bus.mode          = out_ff.mode;
   assign rsp_bus.homed         = out_ff.homed;
   assign rsp_bus.encoder_clear = out_ff.encoder_clear;
   assign rsp_bus.stepped       = out_ff.stepped;

   `SMHS_ASSERT_NOW(ap_phase_onehot, out_valid_ff, $onehot0(out_ff.phase), "phase not one-hot")
   `SMHS_ASSERT_NOW(ap_step_phase, out_valid_ff && out_ff.stepped, out_ff.phase != 4'h0,
                    "step left phase at zero")
   `SMHS_ASSERT_NOW(ap_clear_idle, out_valid_ff && out_ff.encoder_clear,
                    out_ff.mode == MODE_IDLE && out_ff.homed && !out_ff.stepped,
                    "encoder clear outside end of settle")
   `SMHS_ASSERT_NEXT(ap_stage_hold, s1_valid_ff && !fire, s1_valid_ff,
                     "stalled item dropped from input stage")

endmodule

`default_nettype wire

// File: tb/tb_stepper_move_homing_sequencer_top.sv
module tb_stepper_move_homing_sequencer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import smhs_pkg::*;

   localparam int GAP_MAX         = 5;
   localparam int WATCHDOG_LIMIT  = 500;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [2:0] CSR_SPARE_LO = 3'd5;

   typedef struct {
      bit         fixed;
      result_type res;
   } pin_type;

   typedef struct {
      item_type   it;
      bit         fixed;
      result_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset;

   smhs_req_if req_bus ();
   smhs_rsp_if rsp_bus ();
   smhs_csr_if csr_bus ();

   stepper_move_homing_sequencer_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the sequencer state and its registers
   cfg_type     shadow_cfg;
   mode_type    motor_mode;
   logic [3:0]  coil;
   logic [15:0] step_pos;
   logic [16:0] steps_left;
   logic        move_fwd;
   logic        run_fwd;
   logic [7:0]  tick_count;
   logic [15:0] settle_count;
   logic        homed;

   result_type  pending_results[$];
   pin_type     typed_results[$];
   int          failures;
   int          quiet_cycles;
   int          req_gap_max;
   int          rsp_gap_max;

   // One wave-drive step once the interval has elapsed; 1 if a step was made.
   function automatic logic coil_step(input logic fwd, input logic [7:0] interval);
      if (tick_count < interval) return 1'b0;
      tick_count = '0;
      if (fwd) begin
         if (step_pos != 16'hFFFF) step_pos++;
      end else if (step_pos != 16'h0000) begin
         step_pos--;
      end
      if (coil == 4'h0) begin
         coil = shadow_cfg.reverse_direction ? PHASE_FIRST_REV : PHASE_FIRST_FWD;
      end else if (fwd != shadow_cfg.reverse_direction) begin
         coil = (coil == 4'h8) ? 4'h1 : coil << 1;
      end else begin
         coil = (coil == 4'h1) ? 4'h8 : coil >> 1;
      end
      return 1'b1;
   endfunction

   function automatic result_type motor_advance(input item_type it);
      result_type r;
      int         delta;
      logic       stp;
      logic       clr;
      stp = 1'b0;
      clr = 1'b0;
      case (it.op)
         OP_HOME: begin
            homed = 1'b0;
            motor_mode = MODE_HOME;
         end
         OP_MOVE: begin
            delta = int'($signed(it.target));
            if (shadow_cfg.absolute_moves) delta = delta - int'(step_pos);
            motor_mode = MODE_MOVE;
            move_fwd = (delta > 0);
            if (delta < 0) delta = -delta;
            steps_left = (delta > int'(STEPS_MAX)) ? STEPS_MAX : 17'(delta);
         end
         OP_SPEED: begin
            motor_mode = MODE_SPEED;
            run_fwd = it.speed_direction;
         end
         default: begin
            if (tick_count != TICKS_SAT) tick_count++;
            case (motor_mode)
               MODE_HOME: begin
                  // step first, then look at the switch
                  stp = coil_step(1'b0, 8'd1);
                  if (it.home_switch) begin
                     motor_mode = MODE_SETTLE;
                     settle_count = '0;
                     homed = 1'b1;
                     step_pos = '0;
                  end
               end
               MODE_SETTLE: begin
                  if (settle_count != SETTLE_SAT) settle_count++;
                  if (settle_count >= shadow_cfg.settle_ticks) begin
                     clr = 1'b1;
                     motor_mode = MODE_IDLE;
                  end
               end
               MODE_MOVE: begin
                  if (steps_left != '0) begin
                     stp = coil_step(move_fwd, 8'd1);
                     if (stp) steps_left--;
                  end else begin
                     motor_mode = MODE_IDLE;
                  end
               end
               MODE_SPEED: begin
                  if (!it.hold && !(step_pos == '0 && !run_fwd) &&
                      !(step_pos >= shadow_cfg.upper_limit && run_fwd))
                     stp = coil_step(run_fwd, shadow_cfg.speed_interval);
               end
               default: motor_mode = MODE_IDLE;
            endcase
         end
      endcase
      r.phase         = coil;
      r.position      = step_pos;
      r.mode          = motor_mode;
      r.homed         = homed;
      r.encoder_clear = clr;
      r.stepped       = stp;
      return r;
   endfunction

   // Checks results, predicts accepted items, watches for a stall
   always @(posedge clock) begin
      item_type   it;
      result_type got;
      result_type want;
      pin_type    pin;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.phase         = rsp_bus.phase;
            got.position      = rsp_bus.position;
            got.mode          = rsp_bus.mode;
            got.homed         = rsp_bus.homed;
            got.encoder_clear = rsp_bus.encoder_clear;
            got.stepped       = rsp_bus.stepped;
            if (pending_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: unexpected item phase=%h pos=%0d mode=%0d homed=%b",
                           $realtime, got.phase, got.position, got.mode, got.homed);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("%0t: mismatch, expected phase=%h pos=%0d mode=%0d homed=%b",
                              $realtime, want.phase, want.position, want.mode, want.homed);
                     $display("   clear=%b stepped=%b; got phase=%h pos=%0d mode=%0d",
                              want.encoder_clear, want.stepped, got.phase, got.position,
                              got.mode);
                     $display("   homed=%b clear=%b stepped=%b",
                              got.homed, got.encoder_clear, got.stepped);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            it.op              = req_bus.op;
            it.home_switch     = req_bus.home_switch;
            it.hold            = req_bus.hold;
            it.target          = req_bus.target;
            it.speed_direction = req_bus.speed_direction;
            pin  = typed_results.pop_front();
            want = motor_advance(it);
            pending_results.push_back(pin.fixed ? pin.res : want);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // Result side back-pressure
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Leaves valid high so a back-to-back item needs no second assignment
   task automatic send_item(input item_type it, input bit fixed, input result_type res);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_results.push_back('{fixed, res});
      req_bus.valid           <= 1'b1;
      req_bus.op              <= it.op;
      req_bus.home_switch     <= it.home_switch;
      req_bus.hold            <= it.hold;
      req_bus.target          <= it.target;
      req_bus.speed_direction <= it.speed_direction;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_REVERSE:   shadow_cfg.reverse_direction = data[0];
         CSR_SPEED_INT: shadow_cfg.speed_interval    = data[7:0];
         CSR_ABSOLUTE:  shadow_cfg.absolute_moves    = data[0];
         CSR_UPPER:     shadow_cfg.upper_limit       = data;
         CSR_SETTLE:    shadow_cfg.settle_ticks      = data;
         default: ;
      endcase
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic item_type mk(input op_type op, input logic sw, input logic hold,
                                   input logic signed [16:0] target, input logic sdir);
      item_type it;
      it.op              = op;
      it.home_switch     = sw;
      it.hold            = hold;
      it.target          = target;
      it.speed_direction = sdir;
      return it;
   endfunction

   function automatic result_type res(input logic [3:0] phase, input logic [15:0] pos,
                                      input mode_type mode, input logic hm,
                                      input logic clr, input logic stp);
      result_type r;
      r.phase         = phase;
      r.position      = pos;
      r.mode          = mode;
      r.homed         = hm;
      r.encoder_clear = clr;
      r.stepped       = stp;
      return r;
   endfunction

   initial begin
      row_type  rows[$];
      cfg_type  phase_cfg[PHASES];
      item_type it;
      int       roll;

      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.op              <= OP_TICK;
      req_bus.home_switch     <= 1'b0;
      req_bus.hold            <= 1'b0;
      req_bus.target          <= '0;
      req_bus.speed_direction <= 1'b0;
      csr_bus.valid           <= 1'b0;
      csr_bus.index           <= CSR_REVERSE;
      csr_bus.data            <= '0;

      shadow_cfg   = '{1'b0, RST_SPEED_INT, 1'b0, RST_UPPER_LIMIT, RST_SETTLE_TICKS};
      motor_mode   = MODE_IDLE;
      coil         = '0;
      step_pos     = '0;
      steps_left   = '0;
      move_fwd     = 1'b0;
      run_fwd      = 1'b0;
      tick_count   = TICKS_SAT;
      settle_count = '0;
      homed        = 1'b0;
      failures     = 0;
      quiet_cycles = 0;
      req_gap_max  = GAP_MAX;
      rsp_gap_max  = GAP_MAX;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ignored fields at their extremes first, then a short homing run and the start of a move
      rows.push_back('{mk(OP_TICK, 1'b1, 1'b1, 17'sh0FFFF, 1'b1), 1'b1,
                       res(4'h0, 16'd0, MODE_IDLE, 1'b0, 1'b0, 1'b0)});
      rows.push_back('{mk(OP_HOME, 1'b1, 1'b1, 17'sh10001, 1'b1), 1'b1,
                       res(4'h0, 16'd0, MODE_HOME, 1'b0, 1'b0, 1'b0)});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b1,
                       res(4'h1, 16'd0, MODE_HOME, 1'b0, 1'b0, 1'b1)});
      rows.push_back('{mk(OP_TICK, 1'b1, 1'b0, 17'sh00000, 1'b0), 1'b1,
                       res(4'h8, 16'd0, MODE_SETTLE, 1'b1, 1'b0, 1'b1)});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b1,
                       res(4'h8, 16'd0, MODE_SETTLE, 1'b1, 1'b0, 1'b0)});
      rows.push_back('{mk(OP_MOVE, 1'b0, 1'b0, 17'sh0FFFF, 1'b0), 1'b1,
                       res(4'h8, 16'd0, MODE_MOVE, 1'b1, 1'b0, 1'b0)});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b1,
                       res(4'h1, 16'd1, MODE_MOVE, 1'b1, 1'b0, 1'b1)});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      // most negative distance; position runs down to zero and stops there
      rows.push_back('{mk(OP_MOVE, 1'b0, 1'b0, 17'sh10000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      // zero distance: next tick goes idle
      rows.push_back('{mk(OP_MOVE, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      // speed backward at zero, then forward with a held tick
      rows.push_back('{mk(OP_SPEED, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_SPEED, 1'b0, 1'b0, 17'sh00000, 1'b1), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b1, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_HOME, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b1, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      rows.push_back('{mk(OP_TICK, 1'b0, 1'b0, 17'sh00000, 1'b0), 1'b0, '0});
      foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].res);

      // zero interval and zero settle are outside the usual range but allowed
      phase_cfg[0] = '{1'b0, 8'd1,   1'b0, 16'd20,    16'd3};
      phase_cfg[1] = '{1'b1, 8'd0,   1'b1, 16'd0,     16'd0};
      phase_cfg[2] = '{1'b1, 8'd255, 1'b0, 16'd65535, 16'd1};
      phase_cfg[3] = '{1'b0, 8'd3,   1'b1, 16'd30,    16'd65535};
      phase_cfg[4] = '{1'b1, 8'd2,   1'b0, 16'd10,    16'd5};
      phase_cfg[7] = '{1'b0, 8'd1,   1'b1, 16'd65535, 16'd2};

      for (int p = 0; p < PHASES; p++) begin
         wait_results_drained();
         if (p == 5 || p == 6)
            phase_cfg[p] = '{1'($urandom_range(0, 1)), 8'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), 16'($urandom_range(0, 60)),
                             16'($urandom_range(0, 10))};
         csr_write(CSR_REVERSE,   {15'($urandom), phase_cfg[p].reverse_direction});
         csr_write(CSR_SPEED_INT, {8'($urandom), phase_cfg[p].speed_interval});
         csr_write(CSR_ABSOLUTE,  {15'($urandom), phase_cfg[p].absolute_moves});
         csr_write(CSR_UPPER,     phase_cfg[p].upper_limit);
         csr_write(CSR_SETTLE,    phase_cfg[p].settle_ticks);
         if (p % 2 == 0)
            csr_write(CSR_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom));
         csr_bus.valid <= 1'b0;

         req_gap_max = (p % 4 == 1 || p == PHASES - 1) ? 0 : GAP_MAX;
         rsp_gap_max = (p % 4 == 2 || p == PHASES - 1) ? 0 : GAP_MAX;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            it.op = (roll < 72) ? OP_TICK : (roll < 80) ? OP_HOME :
                    (roll < 92) ? OP_MOVE : OP_SPEED;
            it.home_switch     = ($urandom_range(0, 5) == 0);
            it.hold            = ($urandom_range(0, 3) == 0);
            // mostly short moves near the origin, now and then any value
            it.target          = ($urandom_range(0, 9) == 0) ? 17'($urandom) :
                                 17'(int'($urandom_range(0, 50)) - 20);
            it.speed_direction = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, '0);
         end
      end

      wait_results_drained();
      if (failures == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
